// ----- rtl/assert_macros.svh -----
// assertion helpers, clocked on clk_i
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define G2P_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked on every edge
`define G2P_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/g2p_pkg.sv -----
package g2p_pkg;

  localparam int GROUND_FRAC_BITS = 16;

  localparam int GW  = 48;
  localparam int CW  = 64;
  localparam int XW  = 32;
  localparam int IW  = 5;
  localparam int CSH = CW / 2 - GROUND_FRAC_BITS;
  localparam int DW  = ((GW > CW - CSH) ? GW : CW - CSH) + 1;
  localparam int PW  = 2 * CW;
  localparam int EW  = PW + 2;
  localparam int SW  = PW - CW / 2 + 2;
  localparam int QB  = CW - 1;
  localparam int QIW = $clog2(QB);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PROJ = 1'b1;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_NODEN = 1'b1;

  localparam logic [IW-1:0] CI_ROT = 5'd0;
  localparam logic [IW-1:0] CI_CX  = 5'd9;
  localparam logic [IW-1:0] CI_FOC = 5'd12;
  localparam logic [IW-1:0] CI_PPX = 5'd13;
  localparam logic [IW-1:0] CI_A11 = 5'd15;
  localparam logic [IW-1:0] CI_A12 = 5'd16;
  localparam logic [IW-1:0] CI_A13 = 5'd17;
  localparam logic [IW-1:0] CI_A21 = 5'd18;
  localparam logic [IW-1:0] CI_A22 = 5'd19;
  localparam logic [IW-1:0] CI_A23 = 5'd20;

  localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    logic          v;
    logic          op;
    logic [IW-1:0] idx;
    logic [CW-1:0] val;
    logic          nd;
  } tag_t;

  typedef logic signed [2*(CW/2+1)-1:0] pp_t;

  typedef struct packed {
    pp_t ll;
    pp_t lh;
    pp_t hl;
    pp_t hh;
  } pp4_t;

  typedef struct packed {
    logic            ovf0;
    logic            ovf1;
    logic            neg0;
    logic            neg1;
    logic [CW-1:0]   den;
    logic [CW-1:0]   r0;
    logic [CW-1:0]   r1;
    logic [QB-1:0]   q0;
    logic [QB-1:0]   q1;
    logic [CW/2-2:0] n0;
    logic [CW/2-2:0] n1;
  } dv_t;

  function automatic logic ld_hit(input tag_t t, input logic [IW-1:0] idx);
    return t.v && (t.op == OP_LOAD) && (t.idx == idx);
  endfunction

  function automatic pp4_t mul_parts(input logic [CW-1:0] a, input logic [CW-1:0] b);
    pp4_t p;
    logic signed [CW/2:0] al;
    logic signed [CW/2:0] ah;
    logic signed [CW/2:0] bl;
    logic signed [CW/2:0] bh;
    al = {1'b0, a[CW/2-1:0]};
    ah = {a[CW-1], a[CW-1:CW/2]};
    bl = {1'b0, b[CW/2-1:0]};
    bh = {b[CW-1], b[CW-1:CW/2]};
    p.ll = al * bl;
    p.lh = al * bh;
    p.hl = ah * bl;
    p.hh = ah * bh;
    return p;
  endfunction

  function automatic logic signed [PW-1:0] join4(input pp4_t p);
    logic signed [PW-1:0] hh;
    logic signed [PW-1:0] lh;
    logic signed [PW-1:0] hl;
    logic signed [PW-1:0] ll;
    hh = PW'($signed(p.hh));
    lh = PW'($signed(p.lh));
    hl = PW'($signed(p.hl));
    ll = PW'($signed(p.ll));
    return (hh <<< CW) + (lh <<< (CW/2)) + (hl <<< (CW/2)) + ll;
  endfunction

  function automatic logic [CW-1:0] sat_w(input logic signed [EW-1:0] x);
    if (&x[EW-1:CW-1] || ~|x[EW-1:CW-1]) return x[CW-1:0];
    return x[EW-1] ? SMIN : SMAX;
  endfunction

  function automatic logic [CW-1:0] q_final(input logic ovf, input logic neg,
                                            input logic [QB-1:0] q);
    if (ovf) return neg ? SMIN : SMAX;
    return neg ? -{1'b0, q} : {1'b0, q};
  endfunction

  function automatic dv_t div_step(input dv_t x, input logic b0, input logic b1,
                                   input logic [QIW-1:0] b);
    dv_t         y;
    logic [CW:0] s0;
    logic [CW:0] s1;
    y  = x;
    s0 = {x.r0, b0};
    s1 = {x.r1, b1};
    if (s0 >= {1'b0, x.den}) begin
      y.r0    = CW'(s0 - {1'b0, x.den});
      y.q0[b] = 1'b1;
    end else begin
      y.r0 = s0[CW-1:0];
    end
    if (s1 >= {1'b0, x.den}) begin
      y.r1    = CW'(s1 - {1'b0, x.den});
      y.q1[b] = 1'b1;
    end else begin
      y.r1 = s1[CW-1:0];
    end
    return y;
  endfunction

  function automatic logic [XW-1:0] trunc_sat(input logic signed [SW-1:0] s);
    logic [SW-1:0]        bias;
    logic signed [SW-1:0] t;
    bias = {{(SW-CW/2){1'b0}}, {(CW/2){s[SW-1]}}};
    t    = (s + $signed(bias)) >>> (CW/2);
    if (&t[SW-1:XW-1] || ~|t[SW-1:XW-1]) return t[XW-1:0];
    return t[SW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
  endfunction

endpackage

// ----- rtl/g2p_in_if.sv -----
interface g2p_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [g2p_pkg::IW-1:0]              coef_index;
  logic signed [g2p_pkg::CW-1:0]       coef_value;
  logic signed [g2p_pkg::GW-1:0]       ground_x;
  logic signed [g2p_pkg::GW-1:0]       ground_y;
  logic signed [g2p_pkg::GW-1:0]       ground_z;

  modport source (output valid, opcode, coef_index, coef_value, ground_x, ground_y,
                  ground_z, input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, ground_x, ground_y,
                  ground_z, output ready);
endinterface

// ----- rtl/g2p_out_if.sv -----
interface g2p_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [g2p_pkg::XW-1:0] pixel_col;
  logic signed [g2p_pkg::XW-1:0] pixel_row;
  logic                          status;

  modport source (output valid, pixel_col, pixel_row, status, input ready);
  modport sink   (input valid, pixel_col, pixel_row, status, output ready);
endinterface

// ----- rtl/ground_to_pixel_projection_unit.sv -----
// channel | dir | beat
// in_i    | in  | opcode, coef_index, coef_value, ground_x, ground_y, ground_z
// out_o   | out | pixel_col, pixel_row, status (one beat per projection, none per load)
//
// one beat accepted per cycle while no output beat waits
// projections pass the 63-stage restoring divider, one quotient bit per stage
// loads travel the pipe and update the coefficient copy of the stage that uses it
// reset clears all coefficients to zero at once; no clearing pass
// a waiting output beat holds every stage; input ready drops in the same cycle
`include "assert_macros.svh"

module ground_to_pixel_projection_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  g2p_in_if.sink           in_i,
  g2p_out_if.source        out_o
);

  localparam int QB = g2p_pkg::QB;
  localparam int CW = g2p_pkg::CW;

  logic adv;

  g2p_pkg::tag_t tg_in;
  g2p_pkg::tag_t tg1_q, tg2_q, tg3_q, tg4_q, tg5_q, tg6_q, tg6_d;
  g2p_pkg::tag_t tg7_q, tg8_q, tg9_q, tg10_q, tg11_q, tg12_q, tg13_q, tg14_q;
  g2p_pkg::tag_t tdv_q [QB+1];

  logic [CW-1:0] ctr_q  [3];
  logic [CW-1:0] rot_q  [9];
  logic [CW-1:0] foc_q;
  logic [CW-1:0] ppt_q  [2];
  logic [CW-1:0] aff_q  [4];
  logic [CW-1:0] aoff_q [2];

  logic signed [g2p_pkg::GW-1:0] g1_q  [3];
  logic signed [g2p_pkg::DW-1:0] d2_q  [3];
  g2p_pkg::pp4_t                 pp3_q [9];
  logic signed [g2p_pkg::PW-1:0] pr4_q [9];
  logic [CW-1:0]                 ar5_q [3];
  logic [CW-1:0]                 m6_q  [2];
  logic [CW-1:0]                 den6_q;
  logic                          neg6_q [2];
  g2p_pkg::dv_t                  dv0_d;
  g2p_pkg::dv_t                  dv_d  [QB+1];
  g2p_pkg::dv_t                  dv_q  [QB+1];
  logic [CW-1:0]                 q7_q  [2];
  g2p_pkg::pp4_t                 pp8_q [2];
  logic signed [g2p_pkg::PW-1:0] pr9_q [2];
  logic [CW-1:0]                 im10_q [2];
  logic [CW-1:0]                 p11_q [2];
  g2p_pkg::pp4_t                 pp12_q [4];
  logic signed [g2p_pkg::PW-1:0] pr13_q [4];
  logic signed [g2p_pkg::SW-1:0] s14_q [2];

  logic                          out_v_q;
  logic [g2p_pkg::XW-1:0]        col_q;
  logic [g2p_pkg::XW-1:0]        row_q;
  logic                          status_q;

  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  assign out_o.valid     = out_v_q;
  assign out_o.pixel_col = col_q;
  assign out_o.pixel_row = row_q;
  assign out_o.status    = status_q;

  always_comb begin
    tg_in     = '0;
    tg_in.v   = in_i.valid;
    tg_in.op  = in_i.opcode;
    tg_in.idx = in_i.coef_index;
    tg_in.val = in_i.coef_value;
  end

  always_comb begin
    tg6_d    = tg5_q;
    tg6_d.nd = ~|ar5_q[2];
  end

  // divider setup: quotient of 2^63 or more saturates
  always_comb begin
    dv0_d      = '0;
    dv0_d.den  = den6_q;
    dv0_d.neg0 = neg6_q[0];
    dv0_d.neg1 = neg6_q[1];
    dv0_d.r0   = m6_q[0] >> (CW/2 - 1);
    dv0_d.r1   = m6_q[1] >> (CW/2 - 1);
    dv0_d.ovf0 = (m6_q[0] >> (CW/2 - 1)) >= den6_q;
    dv0_d.ovf1 = (m6_q[1] >> (CW/2 - 1)) >= den6_q;
    dv0_d.n0   = m6_q[0][CW/2-2:0];
    dv0_d.n1   = m6_q[1][CW/2-2:0];
  end

  assign dv_d[0] = dv0_d;

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [1:0] nb;
    if (B >= CW/2) begin : g_nb
      assign nb = {dv_q[j].n1[B-CW/2], dv_q[j].n0[B-CW/2]};
    end else begin : g_zb
      assign nb = 2'b00;
    end
    assign dv_d[j+1] = g2p_pkg::div_step(dv_q[j], nb[0], nb[1], g2p_pkg::QIW'(B));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tg1_q    <= '0;
      tg2_q    <= '0;
      tg3_q    <= '0;
      tg4_q    <= '0;
      tg5_q    <= '0;
      tg6_q    <= '0;
      tdv_q    <= '{default: '0};
      tg7_q    <= '0;
      tg8_q    <= '0;
      tg9_q    <= '0;
      tg10_q   <= '0;
      tg11_q   <= '0;
      tg12_q   <= '0;
      tg13_q   <= '0;
      tg14_q   <= '0;
      out_v_q  <= 1'b0;
    end else if (adv) begin
      tg1_q    <= tg_in;
      tg2_q    <= tg1_q;
      tg3_q    <= tg2_q;
      tg4_q    <= tg3_q;
      tg5_q    <= tg4_q;
      tg6_q    <= tg6_d;
      tdv_q[0] <= tg6_q;
      for (int j = 0; j < QB; j++) begin
        tdv_q[j+1] <= tdv_q[j];
      end
      tg7_q    <= tdv_q[QB];
      tg8_q    <= tg7_q;
      tg9_q    <= tg8_q;
      tg10_q   <= tg9_q;
      tg11_q   <= tg10_q;
      tg12_q   <= tg11_q;
      tg13_q   <= tg12_q;
      tg14_q   <= tg13_q;
      out_v_q  <= tg14_q.v && (tg14_q.op == g2p_pkg::OP_PROJ);
    end
  end

  // coefficient copies, each updated as its load passes the stage that reads it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q  <= '{default: '0};
      rot_q  <= '{default: '0};
      foc_q  <= '0;
      ppt_q  <= '{default: '0};
      aff_q  <= '{default: '0};
      aoff_q <= '{default: '0};
    end else if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (g2p_pkg::ld_hit(tg1_q, g2p_pkg::CI_CX + g2p_pkg::IW'(i))) ctr_q[i] <= tg1_q.val;
      end
      for (int i = 0; i < 9; i++) begin
        if (g2p_pkg::ld_hit(tg2_q, g2p_pkg::CI_ROT + g2p_pkg::IW'(i))) rot_q[i] <= tg2_q.val;
      end
      if (g2p_pkg::ld_hit(tg7_q, g2p_pkg::CI_FOC)) foc_q <= tg7_q.val;
      for (int i = 0; i < 2; i++) begin
        if (g2p_pkg::ld_hit(tg10_q, g2p_pkg::CI_PPX + g2p_pkg::IW'(i))) ppt_q[i] <= tg10_q.val;
      end
      if (g2p_pkg::ld_hit(tg11_q, g2p_pkg::CI_A11)) aff_q[0] <= tg11_q.val;
      if (g2p_pkg::ld_hit(tg11_q, g2p_pkg::CI_A12)) aff_q[1] <= tg11_q.val;
      if (g2p_pkg::ld_hit(tg11_q, g2p_pkg::CI_A21)) aff_q[2] <= tg11_q.val;
      if (g2p_pkg::ld_hit(tg11_q, g2p_pkg::CI_A22)) aff_q[3] <= tg11_q.val;
      if (g2p_pkg::ld_hit(tg13_q, g2p_pkg::CI_A13)) aoff_q[0] <= tg13_q.val;
      if (g2p_pkg::ld_hit(tg13_q, g2p_pkg::CI_A23)) aoff_q[1] <= tg13_q.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_q[0] <= in_i.ground_x;
      g1_q[1] <= in_i.ground_y;
      g1_q[2] <= in_i.ground_z;
      // offset from projection centre
      for (int i = 0; i < 3; i++) begin
        d2_q[i] <= g2p_pkg::DW'(g1_q[i]) - g2p_pkg::DW'($signed(ctr_q[i]) >>> g2p_pkg::CSH);
      end
      // rotation
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pp3_q[3*k+i] <= g2p_pkg::mul_parts(CW'(d2_q[i]), rot_q[3*k+i]);
        end
      end
      for (int n = 0; n < 9; n++) begin
        pr4_q[n] <= g2p_pkg::join4(pp3_q[n]);
      end
      for (int k = 0; k < 3; k++) begin
        ar5_q[k] <= g2p_pkg::sat_w((g2p_pkg::EW'(pr4_q[3*k]) + g2p_pkg::EW'(pr4_q[3*k+1])
                                    + g2p_pkg::EW'(pr4_q[3*k+2])) >>> g2p_pkg::GROUND_FRAC_BITS);
      end
      // magnitudes and signs for the ratio
      for (int k = 0; k < 2; k++) begin
        m6_q[k]   <= ar5_q[k][CW-1] ? -ar5_q[k] : ar5_q[k];
        neg6_q[k] <= ar5_q[k][CW-1] ^ ar5_q[2][CW-1];
      end
      den6_q <= ar5_q[2][CW-1] ? -ar5_q[2] : ar5_q[2];
      for (int j = 0; j <= QB; j++) begin
        dv_q[j] <= dv_d[j];
      end
      q7_q[0] <= g2p_pkg::q_final(dv_q[QB].ovf0, dv_q[QB].neg0, dv_q[QB].q0);
      q7_q[1] <= g2p_pkg::q_final(dv_q[QB].ovf1, dv_q[QB].neg1, dv_q[QB].q1);
      // focal scale and principal point
      for (int k = 0; k < 2; k++) begin
        pp8_q[k]  <= g2p_pkg::mul_parts(foc_q, q7_q[k]);
        pr9_q[k]  <= g2p_pkg::join4(pp8_q[k]);
        im10_q[k] <= g2p_pkg::sat_w((-g2p_pkg::EW'(pr9_q[k])) >>> (CW/2));
        p11_q[k]  <= g2p_pkg::sat_w(g2p_pkg::EW'($signed(im10_q[k]))
                                    + g2p_pkg::EW'($signed(ppt_q[k])));
      end
      // affine to column and row
      pp12_q[0] <= g2p_pkg::mul_parts(aff_q[0], p11_q[0]);
      pp12_q[1] <= g2p_pkg::mul_parts(aff_q[1], p11_q[1]);
      pp12_q[2] <= g2p_pkg::mul_parts(aff_q[2], p11_q[0]);
      pp12_q[3] <= g2p_pkg::mul_parts(aff_q[3], p11_q[1]);
      for (int n = 0; n < 4; n++) begin
        pr13_q[n] <= g2p_pkg::join4(pp12_q[n]);
      end
      for (int r = 0; r < 2; r++) begin
        s14_q[r] <= g2p_pkg::SW'((g2p_pkg::EW'(pr13_q[2*r]) >>> (CW/2))
                                 + (g2p_pkg::EW'(pr13_q[2*r+1]) >>> (CW/2))
                                 + g2p_pkg::EW'($signed(aoff_q[r])));
      end
      col_q    <= tg14_q.nd ? '0 : g2p_pkg::trunc_sat(s14_q[0]);
      row_q    <= tg14_q.nd ? '0 : g2p_pkg::trunc_sat(s14_q[1]);
      status_q <= tg14_q.nd ? g2p_pkg::ST_NODEN : g2p_pkg::ST_OK;
    end
  end

  `G2P_ASSERT(a_noden_zero, out_v_q && status_q == g2p_pkg::ST_NODEN |-> col_q == '0 && row_q == '0, "no-denominator beat carries nonzero pixel")
  `G2P_ASSERT_ALWAYS(a_stall_blocks, out_v_q && !out_o.ready |-> !in_i.ready, "input taken while output beat waits")
  `G2P_ASSERT(a_proj_delivered, adv && tg14_q.v && tg14_q.op == g2p_pkg::OP_PROJ |=> out_v_q, "projection dropped at output register")
  `G2P_ASSERT(a_div_rem, tdv_q[QB].v && tdv_q[QB].op == g2p_pkg::OP_PROJ && !tdv_q[QB].nd && !dv_q[QB].ovf0 |-> dv_q[QB].r0 < dv_q[QB].den, "divider remainder not below divisor")

endmodule

// ----- verif/g2p_projection_checker.sv -----
`timescale 1ns / 1ps

module g2p_projection_checker (
  input  logic clk_i,
  input  logic rst_ni,
  g2p_in_if    in_m,
  g2p_out_if   out_m,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int NUM_COEFS = g2p_pkg::CI_A23 + 1;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [g2p_pkg::XW-1:0] col;
    logic signed [g2p_pkg::XW-1:0] row;
    logic                          status;
  } pixel_t;

  pixel_t                        expected_pixels[$];
  logic signed [g2p_pkg::CW-1:0] coef_mem[NUM_COEFS];

  function automatic logic signed [g2p_pkg::CW-1:0] clamp64(input wide_t v);
    if (&v[127:g2p_pkg::CW-1] || ~|v[127:g2p_pkg::CW-1]) return v[g2p_pkg::CW-1:0];
    return v[127] ? g2p_pkg::SMIN : g2p_pkg::SMAX;
  endfunction

  function automatic logic signed [g2p_pkg::XW-1:0] affine_pixel(input wide_t a, input wide_t b,
                                                                 input wide_t k, input wide_t px,
                                                                 input wide_t py);
    wide_t s;
    wide_t t;
    s = ((a * px) >>> 32) + ((b * py) >>> 32) + k;
    t = s / 128'sd4294967296;
    if (t > 128'sd2147483647) return 32'sh7fffffff;
    if (t < -128'sd2147483648) return 32'sh80000000;
    return t[g2p_pkg::XW-1:0];
  endfunction

  function automatic pixel_t project_point(input logic signed [g2p_pkg::GW-1:0] gx,
                                           input logic signed [g2p_pkg::GW-1:0] gy,
                                           input logic signed [g2p_pkg::GW-1:0] gz);
    pixel_t p;
    wide_t  d[3];
    wide_t  acc;
    wide_t  ar[3];
    wide_t  rc;
    wide_t  q;
    wide_t  img;
    wide_t  pxy[2];
    d[0] = wide_t'(gx) - wide_t'(coef_mem[g2p_pkg::CI_CX] >>> g2p_pkg::CSH);
    d[1] = wide_t'(gy) - wide_t'(coef_mem[g2p_pkg::CI_CX+1] >>> g2p_pkg::CSH);
    d[2] = wide_t'(gz) - wide_t'(coef_mem[g2p_pkg::CI_CX+2] >>> g2p_pkg::CSH);
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        rc  = wide_t'(coef_mem[g2p_pkg::CI_ROT + k*3 + i]);
        acc = acc + d[i] * rc;
      end
      ar[k] = wide_t'(clamp64(acc >>> g2p_pkg::GROUND_FRAC_BITS));
    end
    if (ar[2] == 0) begin
      p.col    = '0;
      p.row    = '0;
      p.status = g2p_pkg::ST_NODEN;
      return p;
    end
    for (int k = 0; k < 2; k++) begin
      q      = wide_t'(clamp64((ar[k] <<< 32) / ar[2]));
      rc     = wide_t'(coef_mem[g2p_pkg::CI_FOC]);
      img    = wide_t'(clamp64((-(rc * q)) >>> 32));
      rc     = wide_t'(coef_mem[g2p_pkg::CI_PPX + k]);
      pxy[k] = wide_t'(clamp64(img + rc));
    end
    p.col = affine_pixel(wide_t'(coef_mem[g2p_pkg::CI_A11]), wide_t'(coef_mem[g2p_pkg::CI_A12]),
                         wide_t'(coef_mem[g2p_pkg::CI_A13]), pxy[0], pxy[1]);
    p.row = affine_pixel(wide_t'(coef_mem[g2p_pkg::CI_A21]), wide_t'(coef_mem[g2p_pkg::CI_A22]),
                         wide_t'(coef_mem[g2p_pkg::CI_A23]), pxy[0], pxy[1]);
    p.status = g2p_pkg::ST_OK;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) coef_mem[i] = '0;
      expected_pixels.delete();
      fail_count_o = 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected beat col %0d row %0d status %0b", $time,
                   out_m.pixel_col, out_m.pixel_row, out_m.status);
          fail_count_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.col !== out_m.pixel_col || want.row !== out_m.pixel_row ||
              want.status !== out_m.status) begin
            $display("%0t: expected col %0d row %0d status %0b, got col %0d row %0d status %0b",
                     $time, want.col, want.row, want.status,
                     out_m.pixel_col, out_m.pixel_row, out_m.status);
            fail_count_o++;
          end
        end
      end
      if (in_m.valid && in_m.ready) begin
        if (in_m.opcode == g2p_pkg::OP_PROJ) begin
          expected_pixels.push_back(project_point(in_m.ground_x, in_m.ground_y,
                                                  in_m.ground_z));
        end else if (in_m.coef_index < NUM_COEFS) begin
          coef_mem[in_m.coef_index] = in_m.coef_value;
        end
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

// ----- verif/ground_to_pixel_projection_unit_test.sv -----
`timescale 1ns / 1ps

module ground_to_pixel_projection_unit_test;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   quiet;
  bit   drained;
  int   n_proj;
  int   n_load;

  logic signed [g2p_pkg::CW-1:0] cam_centre[3];

  g2p_in_if  in_i();
  g2p_out_if out_o();

  ground_to_pixel_projection_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  g2p_projection_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_m         (in_i),
    .out_m        (out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("ground_to_pixel_projection_unit_test NOT OK");
    $finish;
  end

  function automatic logic signed [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_beat(input logic op, input logic [g2p_pkg::IW-1:0] idx,
                           input logic signed [g2p_pkg::CW-1:0] val,
                           input logic signed [g2p_pkg::GW-1:0] gx,
                           input logic signed [g2p_pkg::GW-1:0] gy,
                           input logic signed [g2p_pkg::GW-1:0] gz);
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_i.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_i.valid      = 1'b1;
    in_i.opcode     = op;
    in_i.coef_index = idx;
    in_i.coef_value = val;
    in_i.ground_x   = gx;
    in_i.ground_y   = gy;
    in_i.ground_z   = gz;
    do @(posedge clk_i); while (!in_i.ready);
    @(negedge clk_i);
    if (op == g2p_pkg::OP_PROJ) n_proj++;
    else n_load++;
  endtask

  task automatic load_coef(input logic [g2p_pkg::IW-1:0] idx,
                           input logic signed [g2p_pkg::CW-1:0] val);
    send_beat(g2p_pkg::OP_LOAD, idx, val, g2p_pkg::GW'(rand64()), g2p_pkg::GW'(rand64()),
              g2p_pkg::GW'(rand64()));
  endtask

  task automatic project(input logic signed [g2p_pkg::GW-1:0] gx,
                         input logic signed [g2p_pkg::GW-1:0] gy,
                         input logic signed [g2p_pkg::GW-1:0] gz);
    send_beat(g2p_pkg::OP_PROJ, g2p_pkg::IW'($urandom()), rand64(), gx, gy, gz);
  endtask

  task automatic load_camera();
    logic signed [g2p_pkg::CW-1:0] v;
    for (int i = 0; i <= g2p_pkg::CI_A23; i++) begin
      if (i < g2p_pkg::CI_CX) v = rand64() >>> 30;
      else if (i < g2p_pkg::CI_FOC) begin
        v = rand64() >>> 14;
        cam_centre[i - g2p_pkg::CI_CX] = v;
      end else if (i == g2p_pkg::CI_FOC) v = {$urandom_range(0, 63), 32'($urandom())};
      else if (i < g2p_pkg::CI_A11) v = rand64() >>> 28;
      else if (i == g2p_pkg::CI_A13 || i == g2p_pkg::CI_A23) v = rand64() >>> 16;
      else v = rand64() >>> 28;
      if ($urandom_range(0, 30) == 0) v = rand64();
      load_coef(g2p_pkg::IW'(i), v);
    end
  endtask

  task automatic project_near();
    logic signed [g2p_pkg::GW-1:0] g[3];
    for (int i = 0; i < 3; i++) begin
      g[i] = g2p_pkg::GW'(cam_centre[i] >>> g2p_pkg::CSH) + g2p_pkg::GW'(rand64() >>> 34);
    end
    project(g[0], g[1], g[2]);
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      out_o.ready = 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
      if (!quiet) begin
        out_o.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
      end
    end
  end

  initial begin
    quiet           = 1'b0;
    drained         = 1'b0;
    n_proj          = 0;
    n_load          = 0;
    rst_ni          = 1'b0;
    out_o.ready     = 1'b0;
    in_i.valid      = 1'b0;
    in_i.opcode     = g2p_pkg::OP_LOAD;
    in_i.coef_index = '0;
    in_i.coef_value = '0;
    in_i.ground_x   = '0;
    in_i.ground_y   = '0;
    in_i.ground_z   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty store gives no denominator
    project(48'sh7fffffffffff, 48'sh800000000000, 48'sh000000010000);
    load_camera();
    project_near();
    project(48'sh7fffffffffff, 48'sh7fffffffffff, 48'sh7fffffffffff);
    project(48'sh800000000000, 48'sh800000000000, 48'sh800000000000);
    project('0, '0, '0);
    load_coef(5'd31, 64'sh7fffffffffffffff);
    load_coef(5'd21, 64'sh8000000000000000);
    project_near();
    // third rotation row cleared
    for (int i = 6; i < 9; i++) load_coef(g2p_pkg::CI_ROT + g2p_pkg::IW'(i), '0);
    project_near();
    load_coef(g2p_pkg::CI_FOC, 64'sh7fffffffffffffff);
    load_coef(g2p_pkg::CI_ROT + g2p_pkg::IW'(8), 64'sh0000000000000001);
    load_coef(g2p_pkg::CI_A11, 64'sh8000000000000000);
    project_near();
    project(48'sh7fffffffffff, 48'sh800000000000, 48'sh7fffffffffff);
    load_coef(g2p_pkg::CI_A22, 64'sh7fffffffffffffff);
    project_near();

    while (n_proj + n_load < 1100) begin
      if (n_proj + n_load > 1000) quiet = 1'b1;
      if (!drained && n_proj + n_load > 500) begin
        in_i.valid = 1'b0;
        wait (pending == 0);
        drained = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: load_coef(g2p_pkg::IW'($urandom()), rand64());
        1: project(g2p_pkg::GW'(rand64()), g2p_pkg::GW'(rand64()), g2p_pkg::GW'(rand64()));
        2: load_camera();
        default: repeat ($urandom_range(1, 30)) project_near();
      endcase
    end
    in_i.valid = 1'b0;

    wait (pending == 0);
    repeat (120) @(posedge clk_i);
    $display("covered %0d projections and %0d coefficient loads", n_proj, n_load);
    $display("incl. empty store, zero denominator, ignored slots and saturation");
    if (fail_count == 0) begin
      $display("ground_to_pixel_projection_unit_test OK");
    end else begin
      $display("ground_to_pixel_projection_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/g2p_pkg.sv
rtl/g2p_in_if.sv
rtl/g2p_out_if.sv
rtl/ground_to_pixel_projection_unit.sv
verif/g2p_projection_checker.sv
verif/ground_to_pixel_projection_unit_test.sv
